// ===== design/qvat_pkg.sv =====
// package: types, constants and helpers for the quad vertex transform core
`timescale 1ns / 1ps
package qvat_pkg;

   localparam int CoordWidth      = 24;
   localparam int CordicStepsDef  = 16;
   localparam int NumVerticesDef  = 4;
   localparam int AtanEntries     = 24;
   localparam int CordicWidth     = 34;
   localparam int AngleWidth      = 34;

   localparam logic [1:0] CMD_LOAD      = 2'd0;
   localparam logic [1:0] CMD_TRANSLATE = 2'd1;
   localparam logic [1:0] CMD_SCALE     = 2'd2;
   localparam logic [1:0] CMD_ROTATE    = 2'd3;

   localparam logic signed [CoordWidth-1:0] CoordMax = 24'sh7FFFFF;
   localparam logic signed [CoordWidth-1:0] CoordMin = -24'sh800000;
   localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;

   localparam logic signed [15:0] Deg360 = 16'sd23040;

   typedef struct packed {
      logic [1:0]                   cmd;
      logic [1:0]                   vertex_sel;
      logic signed [CoordWidth-1:0] load_x;
      logic signed [CoordWidth-1:0] load_y;
      logic signed [CoordWidth-1:0] shift_x;
      logic signed [CoordWidth-1:0] shift_y;
      logic signed [15:0]           factor_x;
      logic signed [15:0]           factor_y;
      logic signed [15:0]           angle_deg;
   } req_type;

   typedef struct packed {
      logic [1:0]                   vertex_id;
      logic signed [CoordWidth-1:0] pos_x;
      logic signed [CoordWidth-1:0] pos_y;
      logic                         last_vertex;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic cordic_init;
      logic cordic_step;
      logic mul_a;
      logic mul_b;
      logic writeback;
      logic load_write;
   } dp_cmd_type;

   function automatic logic signed [AngleWidth-1:0] atan_lookup(input logic [4:0] idx);
      logic signed [AngleWidth-1:0] r;
      unique case (idx)
         5'd0:  r = 34'sd188743680;
         5'd1:  r = 34'sd111421900;
         5'd2:  r = 34'sd58872272;
         5'd3:  r = 34'sd29884485;
         5'd4:  r = 34'sd15000234;
         5'd5:  r = 34'sd7507429;
         5'd6:  r = 34'sd3754631;
         5'd7:  r = 34'sd1877430;
         5'd8:  r = 34'sd938729;
         5'd9:  r = 34'sd469366;
         5'd10: r = 34'sd234683;
         5'd11: r = 34'sd117342;
         5'd12: r = 34'sd58671;
         5'd13: r = 34'sd29335;
         5'd14: r = 34'sd14668;
         5'd15: r = 34'sd7334;
         5'd16: r = 34'sd3667;
         5'd17: r = 34'sd1833;
         5'd18: r = 34'sd917;
         5'd19: r = 34'sd458;
         5'd20: r = 34'sd229;
         5'd21: r = 34'sd115;
         5'd22: r = 34'sd57;
         5'd23: r = 34'sd29;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [CoordWidth-1:0] sat24(input logic signed [63:0] v);
      logic signed [CoordWidth-1:0] r;
      if (v > 64'sd8388607) r = CoordMax;
      else if (v < -64'sd8388608) r = CoordMin;
      else r = v[CoordWidth-1:0];
      return r;
   endfunction

   function automatic logic signed [CoordWidth-1:0] reset_x(input int idx);
      logic signed [CoordWidth-1:0] r;
      if ((idx % 4) == 1 || (idx % 4) == 2) r = 24'sd28160;
      else r = 24'sd2560;
      return r;
   endfunction

   function automatic logic signed [CoordWidth-1:0] reset_y(input int idx);
      logic signed [CoordWidth-1:0] r;
      if ((idx % 4) >= 2) r = 24'sd28160;
      else r = 24'sd2560;
      return r;
   endfunction

endpackage

// ===== design/quad_vertex_affine_transform_core.sv =====
// top level: quad vertex affine transform core
// sequence: load writes one vertex, then the results; translate and scale pass each vertex
// updated via MUL_A, WRITE; rotate runs cordic, then MUL_A, MUL_B, WRITE via the shared multiplier
// results: NUM_VERTICES items, one per cycle without stall; next item taken after the last
// synchronous reset restores the default square and idles the controller
`timescale 1ns / 1ps
module quad_vertex_affine_transform_core import qvat_pkg::*; #(
   parameter int CORDIC_STEPS = CordicStepsDef,
   parameter int NUM_VERTICES = NumVerticesDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int VW = $clog2(NUM_VERTICES);

   dp_cmd_type    dp_cmd;
   logic [VW-1:0] vidx;
   logic [4:0]    step_idx;
   logic          last_flag;

   assign last_flag = (vidx == VW'(NUM_VERTICES - 1));

   qvat_ctrl #(.CORDIC_STEPS(CORDIC_STEPS), .NUM_VERTICES(NUM_VERTICES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .vidx      (vidx),
      .step_idx  (step_idx),
      .dp_cmd    (dp_cmd)
   );

   qvat_dp #(.NUM_VERTICES(NUM_VERTICES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .dp_cmd    (dp_cmd),
      .vidx      (vidx),
      .step_idx  (step_idx),
      .last_flag (last_flag),
      .rsp       (rsp_data)
   );

endmodule

// ===== design/qvat_ctrl.sv =====
// controller: sequences capture, cordic, per-vertex update and result delivery
`timescale 1ns / 1ps
module qvat_ctrl import qvat_pkg::*; #(
   parameter int CORDIC_STEPS = CordicStepsDef,
   parameter int NUM_VERTICES = NumVerticesDef
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_cmd,
   output logic       req_stall,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [$clog2(NUM_VERTICES)-1:0] vidx,
   output logic [4:0] step_idx,
   output dp_cmd_type dp_cmd
);

   localparam int VW = $clog2(NUM_VERTICES);
   localparam logic [VW-1:0] LastIdx = VW'(NUM_VERTICES - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CORDIC = 3'd1;
   localparam logic [2:0] ST_MUL_A  = 3'd2;
   localparam logic [2:0] ST_MUL_B  = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [VW-1:0] vidx_ff, vidx_in;
   logic [4:0]    step_ff, step_in;

   logic accept;
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign vidx      = vidx_ff;
   assign step_idx  = step_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      vidx_in  = vidx_ff;
      step_in  = step_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dp_cmd.capture = 1'b1;
               cmd_in  = req_cmd;
               step_in = '0;
               unique case (req_cmd)
                  CMD_LOAD: begin
                     dp_cmd.load_write = 1'b1;
                     vidx_in  = '0;
                     state_in = ST_OUT;
                  end
                  CMD_ROTATE: begin
                     dp_cmd.cordic_init = 1'b1;
                     state_in = ST_CORDIC;
                     vidx_in  = '0;
                  end
                  CMD_SCALE: begin
                     // vertex a stays put
                     vidx_in  = VW'(1);
                     state_in = ST_MUL_A;
                  end
                  default: begin
                     vidx_in  = '0;
                     state_in = ST_MUL_A;
                  end
               endcase
            end
         end
         ST_CORDIC: begin
            dp_cmd.cordic_step = 1'b1;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CORDIC_STEPS - 1)) state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            dp_cmd.mul_a = 1'b1;
            state_in = (cmd_ff == CMD_ROTATE) ? ST_MUL_B : ST_WRITE;
         end
         ST_MUL_B: begin
            dp_cmd.mul_b = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            dp_cmd.writeback = 1'b1;
            if (vidx_ff == LastIdx) begin
               vidx_in  = '0;
               state_in = ST_OUT;
            end else begin
               vidx_in  = vidx_ff + VW'(1);
               state_in = ST_MUL_A;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (vidx_ff == LastIdx) begin
                  vidx_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  vidx_in = vidx_ff + VW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= CMD_LOAD;
         vidx_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         vidx_ff  <= vidx_in;
         step_ff  <= step_in;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("item taken while busy");
   a_out_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_stall && vidx_ff == LastIdx) |=> (state_ff == ST_IDLE))
      else $error("result run did not end after last vertex");
   a_cordic_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (step_ff < 5'(CORDIC_STEPS)))
      else $error("cordic step count overran");

endmodule

// ===== design/qvat_dp.sv =====
// datapath: vertex store, angle reduction, cordic and shared multiplier
`timescale 1ns / 1ps
module qvat_dp import qvat_pkg::*; #(
   parameter int NUM_VERTICES = NumVerticesDef
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req,
   input  dp_cmd_type dp_cmd,
   input  logic [$clog2(NUM_VERTICES)-1:0] vidx,
   input  logic [4:0] step_idx,
   input  logic       last_flag,
   output rsp_type    rsp
);

   localparam int VW = $clog2(NUM_VERTICES);
   localparam int CW = CordicWidth;

   logic signed [CoordWidth-1:0] vx_ff [NUM_VERTICES];
   logic signed [CoordWidth-1:0] vy_ff [NUM_VERTICES];

   logic [1:0]                   cmd_ff;
   logic signed [CoordWidth-1:0] shx_ff, shy_ff;
   logic signed [15:0]           fx_ff, fy_ff;
   logic signed [CW-1:0]         cx_ff, cy_ff, cz_ff;
   logic                         flip_ff;
   logic signed [CoordWidth-1:0] ax_ff, ay_ff;
   logic signed [63:0]           px_ff, py_ff;

   // angle reduction to [-90, 90] with flip
   // a 16-bit angle is within one turn of [-180, 180), so one correction suffices
   logic signed [16:0] r;
   logic               flip;
   always_comb begin
      r = 17'(req.angle_deg);
      if (r >= 17'sd11520)       r = r - 17'(Deg360);
      else if (r < -17'sd11520)  r = r + 17'(Deg360);
      flip = 1'b0;
      if (r > 17'sd5760) begin
         r = r - 17'sd11520;
         flip = 1'b1;
      end else if (r < -17'sd5760) begin
         r = r + 17'sd11520;
         flip = 1'b1;
      end
   end

   // one cordic iteration
   logic signed [CW-1:0] sh_x, sh_y, atan_v;
   assign sh_x   = cx_ff >>> step_idx;
   assign sh_y   = cy_ff >>> step_idx;
   assign atan_v = atan_lookup(step_idx);

   logic signed [CW-1:0] cosv, sinv;
   assign cosv = flip_ff ? -cx_ff : cx_ff;
   assign sinv = flip_ff ? -cy_ff : cy_ff;

   logic signed [CoordWidth-1:0] ox, oy;
   assign ox = vx_ff[vidx];
   assign oy = vy_ff[vidx];

   logic signed [63:0] prod_a_x, prod_a_y;
   logic signed [63:0] sum_x, sum_y;
   always_comb begin
      prod_a_x = '0;
      prod_a_y = '0;
      unique case (cmd_ff)
         CMD_SCALE: begin
            prod_a_x = 64'(64'(ox) - 64'(ax_ff)) * 64'(fx_ff);
            prod_a_y = 64'(64'(oy) - 64'(ay_ff)) * 64'(fy_ff);
         end
         CMD_ROTATE: begin
            prod_a_x = 64'(ox) * 64'(cosv);
            prod_a_y = 64'(ox) * 64'(sinv);
         end
         default: begin
            prod_a_x = 64'(ox) + 64'(shx_ff);
            prod_a_y = 64'(oy) + 64'(shy_ff);
         end
      endcase
      sum_x = px_ff - 64'(oy) * 64'(sinv) + (64'sd1 <<< 29);
      sum_y = py_ff + 64'(oy) * 64'(cosv) + (64'sd1 <<< 29);
   end

   logic signed [CoordWidth-1:0] wx, wy;
   always_comb begin
      unique case (cmd_ff)
         CMD_SCALE: begin
            wx = sat24(((px_ff + 64'sd128) >>> 8) + 64'(ax_ff));
            wy = sat24(((py_ff + 64'sd128) >>> 8) + 64'(ay_ff));
         end
         CMD_ROTATE: begin
            wx = sat24(px_ff >>> 30);
            wy = sat24(py_ff >>> 30);
         end
         default: begin
            wx = sat24(px_ff);
            wy = sat24(py_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff  <= req.cmd;
         shx_ff  <= req.shift_x;
         shy_ff  <= req.shift_y;
         fx_ff   <= req.factor_x;
         fy_ff   <= req.factor_y;
         flip_ff <= flip;
         ax_ff   <= vx_ff[0];
         ay_ff   <= vy_ff[0];
      end
      if (dp_cmd.cordic_init) begin
         cx_ff <= CordicGain;
         cy_ff <= '0;
         cz_ff <= CW'(r) <<< 16;
      end else if (dp_cmd.cordic_step) begin
         if (!cz_ff[CW-1]) begin
            cx_ff <= cx_ff - sh_y;
            cy_ff <= cy_ff + sh_x;
            cz_ff <= cz_ff - atan_v;
         end else begin
            cx_ff <= cx_ff + sh_y;
            cy_ff <= cy_ff - sh_x;
            cz_ff <= cz_ff + atan_v;
         end
      end
      if (dp_cmd.mul_a) begin
         px_ff <= prod_a_x;
         py_ff <= prod_a_y;
      end else if (dp_cmd.mul_b) begin
         px_ff <= sum_x;
         py_ff <= sum_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VERTICES; i++) begin
            vx_ff[i] <= reset_x(i);
            vy_ff[i] <= reset_y(i);
         end
      end else if (dp_cmd.load_write) begin
         if (32'(req.vertex_sel) < NUM_VERTICES) begin
            vx_ff[VW'(req.vertex_sel)] <= req.load_x;
            vy_ff[VW'(req.vertex_sel)] <= req.load_y;
         end
      end else if (dp_cmd.writeback) begin
         vx_ff[vidx] <= wx;
         vy_ff[vidx] <= wy;
      end
   end

   assign rsp.vertex_id   = 2'(vidx);
   assign rsp.pos_x       = ox;
   assign rsp.pos_y       = oy;
   assign rsp.last_vertex = last_flag;

endmodule
